/* src/tcw_pkg.sv */
// ============================================================================
// tcw_pkg
// Shared constants, codes and the command record of the text console writer.
// ============================================================================
package tcw_pkg;

    localparam int MAX_COLS   = 80;
    localparam int MAX_LINES  = 25;
    localparam int CELL_COUNT = MAX_LINES * MAX_COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam int LINE_W     = 5;
    localparam int COL_W      = 7;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int OP_W       = 2;
    localparam int NIB_W      = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_IN_USE = 2'd1;

    localparam logic [LINE_W-1:0] ROWS_RESET = 5'd25;
    localparam logic [COL_W-1:0]  COLS_RESET = 7'd80;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_PLAIN   = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL   = {ATTR_PLAIN, CH_SPACE};

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_PUT       = 3'd0,
        KIND_NEWLINE   = 3'd1,
        KIND_BACKSPACE = 3'd2,
        KIND_CLEAR     = 3'd3,
        KIND_READ      = 3'd4,
        KIND_NOP       = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [CHAR_W-1:0]  ch;
        logic [ATTR_W-1:0]  attr;
        logic [LINE_W-1:0]  rd_line;
        logic [COL_W-1:0]   rd_col;
        logic               rd_in_range;
    } cmd_t;

endpackage

/* src/text_console_cell_writer_top.sv */
// ============================================================================
// text_console_cell_writer_top
// Text console cell writer: screen store of character/attribute cells + cursor.
// ============================================================================
// After reset the block blanks every cell of the screen store (spaces,
// attribute 07) with full held high; configuration writes are taken during
// that time. Requests then enter a two-deep command queue and are executed
// one at a time by the back end, which owns the single-port store. A put,
// newline, in-line backspace, no-op or out-of-range read passes from queue
// head to result through fetch and execute; an in-range read adds a wait
// state, as the store read is registered. A backspace at column 0 scans the
// previous line right to left, with a read and a check state per cell. Clear
// writes one cell per cycle over the rows*columns visible cells. The back
// end fetches a command only when the result register is empty or being
// popped, so one result waits at the output while up to two more requests
// queue behind it.
// ============================================================================
module text_console_cell_writer_top
    import tcw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request side
    input  logic                  push,
    output logic                  full,
    input  logic [OP_W-1:0]       op,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic [NIB_W-1:0]      background,
    input  logic [NIB_W-1:0]      foreground,
    input  logic [LINE_W-1:0]     read_line,
    input  logic [COL_W-1:0]      read_column,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output logic [LINE_W-1:0]     cursor_line,
    output logic [COL_W-1:0]      cursor_column,
    output logic [CHAR_W-1:0]     cell_char,
    output logic [ATTR_W-1:0]     cell_attribute,
    output logic                  write_dropped,
    // configuration: index 0 rows_in_use, index 1 columns_in_use
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic q_push, q_pop, q_full, q_empty, init_busy;
    cmd_t q_cmd, q_head;

    // intake and classification
    tcw_front u_front (
        .push        (push),
        .full        (full),
        .op          (op),
        .char_code   (char_code),
        .background  (background),
        .foreground  (foreground),
        .read_line   (read_line),
        .read_column (read_column),
        .q_full      (q_full),
        .init_busy   (init_busy),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    // decoupling queue
    tcw_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // execution, store and result register
    tcw_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_head         (q_head),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .init_busy      (init_busy),
        .empty          (empty),
        .pop            (pop),
        .cursor_line    (cursor_line),
        .cursor_column  (cursor_column),
        .cell_char      (cell_char),
        .cell_attribute (cell_attribute),
        .write_dropped  (write_dropped)
    );

endmodule

/* src/tcw_front.sv */
// ============================================================================
// tcw_front
// Request intake: decodes op and character into a command and queues it.
// ============================================================================
module tcw_front
    import tcw_pkg::*;
(
    input  logic              push,
    output logic              full,
    input  logic [OP_W-1:0]   op,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [NIB_W-1:0]  background,
    input  logic [NIB_W-1:0]  foreground,
    input  logic [LINE_W-1:0] read_line,
    input  logic [COL_W-1:0]  read_column,
    input  logic              q_full,
    input  logic              init_busy,
    output logic              q_push,
    output cmd_t              q_cmd
);

    assign full   = q_full | init_busy;
    assign q_push = push & ~full;

    always_comb
    begin
        q_cmd.ch          = char_code;
        q_cmd.attr        = {background, foreground};
        q_cmd.rd_line     = read_line;
        q_cmd.rd_col      = read_column;
        q_cmd.rd_in_range = (read_line < LINE_W'(MAX_LINES)) &&
                            (read_column < COL_W'(MAX_COLS));
        unique case (op)
            OP_PUT:
            begin
                if (char_code == CH_NEWLINE)
                    q_cmd.kind = KIND_NEWLINE;
                else if (char_code == CH_BACKSPACE)
                    q_cmd.kind = KIND_BACKSPACE;
                else
                    q_cmd.kind = KIND_PUT;
            end
            OP_CLEAR: q_cmd.kind = KIND_CLEAR;
            OP_READ:  q_cmd.kind = KIND_READ;
            default:  q_cmd.kind = KIND_NOP;
        endcase
    end

endmodule

/* src/tcw_cmd_queue.sv */
// ============================================================================
// tcw_cmd_queue
// Short command queue between intake and execution.
// ============================================================================
module tcw_cmd_queue
    import tcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_push,
    input  cmd_t q_cmd,
    input  logic q_pop,
    output cmd_t q_head,
    output logic q_full,
    output logic q_empty
);

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign q_full  = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_push = q_push & ~q_full;
    assign do_pop  = q_pop & ~q_empty;
    assign q_head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 :
                          CMDQ_PTR_W'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 :
                          CMDQ_PTR_W'(rd_ptr_reg + 1'b1);
        if (do_push && !do_pop)
            count_next = CMDQ_CNT_W'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CMDQ_CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= q_cmd;
    end

endmodule

/* src/tcw_back.sv */
// ============================================================================
// tcw_back
// Execution engine: screen store, cursor, config, scans and result register.
// ============================================================================
module tcw_back
    import tcw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  q_head,
    input  logic                  q_empty,
    output logic                  q_pop,
    output logic                  init_busy,
    output logic                  empty,
    input  logic                  pop,
    output logic [LINE_W-1:0]     cursor_line,
    output logic [COL_W-1:0]      cursor_column,
    output logic [CHAR_W-1:0]     cell_char,
    output logic [ATTR_W-1:0]     cell_attribute,
    output logic                  write_dropped
);

    typedef enum logic [6:0] {
        ST_INIT    = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_EXEC    = 7'b0000100,
        ST_BS_RD   = 7'b0001000,
        ST_BS_CHK  = 7'b0010000,
        ST_CLR     = 7'b0100000,
        ST_RD_WAIT = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [LINE_W-1:0]   rows_in_use_reg;
    logic [COL_W-1:0]    columns_in_use_reg;
    logic [LINE_W-1:0]   cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0]    cursor_col_reg, cursor_col_next;
    logic [LINE_W-1:0]   scan_row_reg, scan_row_next;
    logic [COL_W-1:0]    scan_col_reg, scan_col_next;
    logic [ADDR_W-1:0]   init_cnt_reg, init_cnt_next;
    logic                out_valid_reg;
    logic [LINE_W-1:0]   res_line_reg;
    logic [COL_W-1:0]    res_col_reg;
    logic [CHAR_W-1:0]   res_char_reg, res_char_next;
    logic [ATTR_W-1:0]   res_attr_reg, res_attr_next;
    logic                res_drop_reg, res_drop_next;
    logic                res_fire;

    logic [CELL_W-1:0]   mem [CELL_COUNT];
    logic [CELL_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_addr;
    logic [CELL_W-1:0]   mem_wdata;
    logic [LINE_W-1:0]   addr_row;
    logic [COL_W-1:0]    addr_col;

    logic [LINE_W-1:0]   rows_eff;
    logic [COL_W-1:0]    cols_eff;
    logic [COL_W-1:0]    cols_last;
    logic                row_below, col_beyond;
    logic [LINE_W-1:0]   put_row;
    logic [COL_W-1:0]    put_col, put_col_inc;
    logic                put_row_below, put_wrap;
    logic [COL_W-1:0]    bs_col;
    logic [LINE_W-1:0]   bs_row_top;
    logic                rd_is_space;
    logic [COL_W-1:0]    bs_end_raw, bs_end_col;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [LINE_W-1:0] line,
                                                     input logic [COL_W-1:0]  col);
        return ADDR_W'(ADDR_W'(line) * ADDR_W'(MAX_COLS) + ADDR_W'(col));
    endfunction

    // effective geometry, clamped to the store
    assign rows_eff = (rows_in_use_reg == '0) ? LINE_W'(1) :
                      (rows_in_use_reg > LINE_W'(MAX_LINES)) ? LINE_W'(MAX_LINES) :
                      rows_in_use_reg;
    assign cols_eff = (columns_in_use_reg == '0) ? COL_W'(1) :
                      (columns_in_use_reg > COL_W'(MAX_COLS)) ? COL_W'(MAX_COLS) :
                      columns_in_use_reg;
    assign cols_last = COL_W'(cols_eff - 1'b1);

    // put / newline / short backspace helpers
    assign row_below     = (cursor_row_reg >= rows_eff);
    assign col_beyond    = (cursor_col_reg >= cols_eff);
    assign put_row       = col_beyond ? LINE_W'(cursor_row_reg + 1'b1) : cursor_row_reg;
    assign put_col       = col_beyond ? '0 : cursor_col_reg;
    assign put_row_below = (put_row >= rows_eff);
    assign put_col_inc   = COL_W'(put_col + 1'b1);
    assign put_wrap      = (put_col_inc >= cols_eff);
    assign bs_col        = COL_W'(((cursor_col_reg > cols_eff) ? cols_eff : cursor_col_reg)
                                  - 1'b1);
    assign bs_row_top    = (cursor_row_reg > rows_eff) ? rows_eff : cursor_row_reg;

    // line scan helpers
    assign rd_is_space = (rd_data_reg[CHAR_W-1:0] == CH_SPACE);
    assign bs_end_raw  = rd_is_space ? scan_col_reg : COL_W'(scan_col_reg + 1'b1);
    assign bs_end_col  = (bs_end_raw > cols_last) ? cols_last : bs_end_raw;

    assign init_busy = (state_reg == ST_INIT);
    assign mem_addr  = init_busy ? init_cnt_reg : cell_addr(addr_row, addr_col);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        scan_row_next   = scan_row_reg;
        scan_col_next   = scan_col_reg;
        init_cnt_next   = init_cnt_reg;
        res_fire        = 1'b0;
        res_char_next   = '0;
        res_attr_next   = '0;
        res_drop_next   = 1'b0;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = BLANK_CELL;
        addr_row        = scan_row_reg;
        addr_col        = scan_col_reg;

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we = 1'b1;
                if (init_cnt_reg == ADDR_W'(CELL_COUNT - 1))
                    state_next = ST_IDLE;
                else
                    init_cnt_next = ADDR_W'(init_cnt_reg + 1'b1);
            end
            ST_IDLE:
            begin
                if (!q_empty && (!out_valid_reg || pop))
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (cmd_reg.kind)
                    KIND_PUT:
                    begin
                        res_fire = 1'b1;
                        if (row_below)
                            res_drop_next = 1'b1;
                        else if (put_row_below)
                        begin
                            cursor_row_next = put_row;
                            cursor_col_next = '0;
                            res_drop_next   = 1'b1;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {cmd_reg.attr, cmd_reg.ch};
                            addr_row  = put_row;
                            addr_col  = put_col;
                            if (put_wrap)
                            begin
                                cursor_row_next = LINE_W'(put_row + 1'b1);
                                cursor_col_next = '0;
                            end
                            else
                            begin
                                cursor_row_next = put_row;
                                cursor_col_next = put_col_inc;
                            end
                        end
                    end
                    KIND_NEWLINE:
                    begin
                        res_fire = 1'b1;
                        if (row_below)
                            res_drop_next = 1'b1;
                        else
                        begin
                            mem_we          = ~col_beyond;
                            addr_row        = cursor_row_reg;
                            addr_col        = cursor_col_reg;
                            cursor_row_next = LINE_W'(cursor_row_reg + 1'b1);
                            cursor_col_next = '0;
                        end
                    end
                    KIND_BACKSPACE:
                    begin
                        if (cursor_col_reg != '0)
                        begin
                            res_fire        = 1'b1;
                            cursor_col_next = bs_col;
                            addr_row        = cursor_row_reg;
                            addr_col        = bs_col;
                            if (row_below)
                                res_drop_next = 1'b1;
                            else
                                mem_we = 1'b1;
                        end
                        else if (bs_row_top == '0)
                            res_fire = 1'b1;
                        else
                        begin
                            scan_row_next = LINE_W'(bs_row_top - 1'b1);
                            scan_col_next = cols_last;
                            state_next    = ST_BS_RD;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        scan_row_next = '0;
                        scan_col_next = '0;
                        state_next    = ST_CLR;
                    end
                    KIND_READ:
                    begin
                        if (cmd_reg.rd_in_range)
                        begin
                            addr_row   = cmd_reg.rd_line;
                            addr_col   = cmd_reg.rd_col;
                            state_next = ST_RD_WAIT;
                        end
                        else
                            res_fire = 1'b1;
                    end
                    default: res_fire = 1'b1;
                endcase
            end
            ST_BS_RD:
                state_next = ST_BS_CHK;
            ST_BS_CHK:
            begin
                if ((scan_col_reg != '0) && rd_is_space)
                begin
                    scan_col_next = COL_W'(scan_col_reg - 1'b1);
                    state_next    = ST_BS_RD;
                end
                else
                begin
                    cursor_row_next = scan_row_reg;
                    cursor_col_next = bs_end_col;
                    res_fire        = 1'b1;
                end
            end
            ST_CLR:
            begin
                mem_we = 1'b1;
                if (scan_col_reg == cols_last)
                begin
                    if (scan_row_reg == LINE_W'(rows_eff - 1'b1))
                    begin
                        cursor_row_next = '0;
                        cursor_col_next = '0;
                        res_fire        = 1'b1;
                    end
                    else
                    begin
                        scan_row_next = LINE_W'(scan_row_reg + 1'b1);
                        scan_col_next = '0;
                    end
                end
                else
                    scan_col_next = COL_W'(scan_col_reg + 1'b1);
            end
            ST_RD_WAIT:
            begin
                res_char_next = rd_data_reg[CHAR_W-1:0];
                res_attr_next = rd_data_reg[CELL_W-1:CHAR_W];
                res_fire      = 1'b1;
            end
            default: state_next = ST_IDLE;
        endcase

        if (res_fire)
            state_next = ST_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_INIT;
            init_cnt_reg       <= '0;
            cursor_row_reg     <= '0;
            cursor_col_reg     <= '0;
            rows_in_use_reg    <= ROWS_RESET;
            columns_in_use_reg <= COLS_RESET;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_cnt_reg   <= init_cnt_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            if (cfg_write && (cfg_index == REG_ROWS_IN_USE))
                rows_in_use_reg <= cfg_data[LINE_W-1:0];
            if (cfg_write && (cfg_index == REG_COLUMNS_IN_USE))
                columns_in_use_reg <= cfg_data[COL_W-1:0];
            if (res_fire)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        scan_row_reg <= scan_row_next;
        scan_col_reg <= scan_col_next;
        if (res_fire)
        begin
            res_line_reg <= cursor_row_next;
            res_col_reg  <= cursor_col_next;
            res_char_reg <= res_char_next;
            res_attr_reg <= res_attr_next;
            res_drop_reg <= res_drop_next;
        end
    end

    // screen store, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[mem_addr];
    end

    assign empty          = ~out_valid_reg;
    assign cursor_line    = res_line_reg;
    assign cursor_column  = res_col_reg;
    assign cell_char      = res_char_reg;
    assign cell_attribute = res_attr_reg;
    assign write_dropped  = res_drop_reg;

`ifndef SYNTHESIS
    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |-> !out_valid_reg)
        else $error("result produced while result register occupied");

    a_fetch_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE) && !q_empty)
        else $error("command fetched outside idle or from empty queue");

    a_cursor_col_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_col_reg < COL_W'(MAX_COLS))
        else $error("cursor column beyond store width");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> mem_addr < ADDR_W'(CELL_COUNT))
        else $error("screen write outside store");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(res_line_reg)
                                  && $stable(res_col_reg))
        else $error("waiting result lost or changed");
`endif

endmodule

/* tb/text_console_cell_writer_top_tb.sv */
// ----------------------------------------------------------------------------
// text_console_cell_writer_top_tb
// Self-checking bench for the text console cell writer. A queue-fed driver
// sends put, clear, read and no-op requests, and a scoreboard keeps its own
// copy of the screen, cursor and screen size to predict the cursor and cell
// data of every result. Screen size changes only between phases, while the
// block is idle.
// ----------------------------------------------------------------------------
module text_console_cell_writer_top_tb
    import tcw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 9;
    localparam int PHASES           = 10;
    localparam int RANDOM_PER_PHASE = 93;
    localparam int TAIL_CYCLES      = 50;
    localparam int REPORT_CAP       = 100;

    // op code 3 has no package name; the block treats it as a no-op
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [NIB_W-1:0]  bg;
        logic [NIB_W-1:0]  fg;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
    } console_cmd_t;

    typedef struct packed {
        logic [LINE_W-1:0] row;
        logic [COL_W-1:0]  column;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic              dropped;
    } console_status_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic                  push           = 1'b0;
    logic                  full;
    logic [OP_W-1:0]       op             = '0;
    logic [CHAR_W-1:0]     char_code      = '0;
    logic [NIB_W-1:0]      background     = '0;
    logic [NIB_W-1:0]      foreground     = '0;
    logic [LINE_W-1:0]     read_line      = '0;
    logic [COL_W-1:0]      read_column    = '0;
    logic                  empty;
    logic                  pop            = 1'b0;
    logic [LINE_W-1:0]     cursor_line;
    logic [COL_W-1:0]      cursor_column;
    logic [CHAR_W-1:0]     cell_char;
    logic [ATTR_W-1:0]     cell_attribute;
    logic                  write_dropped;
    logic                  cfg_write      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    always #CLK_HALF clk = ~clk;

    text_console_cell_writer_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .op             (op),
        .char_code      (char_code),
        .background     (background),
        .foreground     (foreground),
        .read_line      (read_line),
        .read_column    (read_column),
        .empty          (empty),
        .pop            (pop),
        .cursor_line    (cursor_line),
        .cursor_column  (cursor_column),
        .cell_char      (cell_char),
        .cell_attribute (cell_attribute),
        .write_dropped  (write_dropped),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Scoreboard state: our own screen copy ({attr, char} per cell), cursor
    // and the raw register values as last written.
    // ------------------------------------------------------------------------
    logic [CELL_W-1:0] screen_copy [CELL_COUNT];
    int                cur_row  = 0;
    int                cur_col  = 0;
    int                rows_cfg = 0;
    int                cols_cfg = 0;

    console_cmd_t    cmd_backlog [$];   // requests not yet offered
    console_status_t status_due  [$];   // predicted results, oldest first
    console_cmd_t    in_flight;         // request currently on the ports

    int mismatches  = 0;
    int push_wait   = 0;
    int pop_wait    = 0;
    bit push_steady = 1'b0;   // stretch with no sender gaps
    bit pop_steady  = 1'b0;   // stretch with no receiver stalls
    bit draining    = 1'b0;   // sender holds off until all results are in

    // Registers are clamped to 1..MAX inside the block
    function automatic int vis_rows();
        if (rows_cfg < 1) return 1;
        if (rows_cfg > MAX_LINES) return MAX_LINES;
        return rows_cfg;
    endfunction

    function automatic int vis_cols();
        if (cols_cfg < 1) return 1;
        if (cols_cfg > MAX_COLS) return MAX_COLS;
        return cols_cfg;
    endfunction

    function automatic logic [CHAR_W-1:0] char_at(input int r, input int c);
        if (r < MAX_LINES && c < MAX_COLS)
            return screen_copy[r * MAX_COLS + c][CHAR_W-1:0];
        return '0;
    endfunction

    function automatic void write_cell(input int r, input int c,
                                       input logic [CHAR_W-1:0] ch,
                                       input logic [ATTR_W-1:0] attr);
        if (r < MAX_LINES && c < MAX_COLS)
            screen_copy[r * MAX_COLS + c] = {attr, ch};
    endfunction

    // Backspace; returns 1 when the step happened below the screen
    function automatic logic step_back(input int rows, input int cols);
        int r;
        int c;
        if (cur_col == 0)
        begin
            // below a shrunken screen we land on the last visible line
            r = (cur_row > rows) ? rows : cur_row;
            if (r == 0)
                return 1'b0;
            r--;
            // scan right to left for the last non-space cell, stop at column 0
            c = cols - 1;
            while (c > 0 && char_at(r, c) == CH_SPACE)
                c--;
            if (char_at(r, c) != CH_SPACE)
                c++;
            if (c > cols - 1)
                c = cols - 1;
            cur_row = r;
            cur_col = c;
            return 1'b0;
        end
        c = (cur_col > cols) ? cols : cur_col;
        c--;
        cur_col = c;
        if (cur_row >= rows)
            return 1'b1;
        write_cell(cur_row, c, CH_SPACE, ATTR_PLAIN);
        return 1'b0;
    endfunction

    // Put character, newline or backspace; returns the dropped flag
    function automatic logic put_char(input logic [CHAR_W-1:0] ch,
                                      input logic [ATTR_W-1:0] attr,
                                      input int rows, input int cols);
        if (ch == CH_NEWLINE)
        begin
            if (cur_row >= rows)
                return 1'b1;
            // cursor past the visible width: no blank to write
            if (cur_col < cols)
                write_cell(cur_row, cur_col, CH_SPACE, ATTR_PLAIN);
            cur_row++;
            cur_col = 0;
            return 1'b0;
        end
        if (ch == CH_BACKSPACE)
            return step_back(rows, cols);
        if (cur_row >= rows)
            return 1'b1;
        if (cur_col >= cols)
        begin
            cur_row++;
            cur_col = 0;
            if (cur_row >= rows)
                return 1'b1;
        end
        write_cell(cur_row, cur_col, ch, attr);
        cur_col++;
        if (cur_col >= cols)
        begin
            cur_col = 0;
            cur_row++;
        end
        return 1'b0;
    endfunction

    // Apply one accepted request to the screen copy and give its result
    function automatic console_status_t next_status(input console_cmd_t cmd);
        console_status_t st;
        logic [CELL_W-1:0] stored;
        int rows;
        int cols;
        rows = vis_rows();
        cols = vis_cols();
        st   = '0;
        case (cmd.op)
            OP_PUT:
                st.dropped = put_char(cmd.ch, {cmd.bg, cmd.fg}, rows, cols);
            OP_CLEAR:
            begin
                // visible area only; cells outside it keep their contents
                for (int r = 0; r < rows; r++)
                    for (int c = 0; c < cols; c++)
                        write_cell(r, c, CH_SPACE, ATTR_PLAIN);
                cur_row = 0;
                cur_col = 0;
            end
            OP_READ:
                if (cmd.line < MAX_LINES && cmd.col < MAX_COLS)
                begin
                    stored  = screen_copy[int'(cmd.line) * MAX_COLS + int'(cmd.col)];
                    st.ch   = stored[CHAR_W-1:0];
                    st.attr = stored[CELL_W-1:CHAR_W];
                end
            default: ;
        endcase
        st.row    = cur_row[LINE_W-1:0];
        st.column = cur_col[COL_W-1:0];
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit steady);
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_cmd(input logic [OP_W-1:0] o,
                                    input logic [CHAR_W-1:0] ch,
                                    input logic [NIB_W-1:0] bg,
                                    input logic [NIB_W-1:0] fg,
                                    input logic [LINE_W-1:0] line,
                                    input logic [COL_W-1:0] col);
        console_cmd_t cmd;
        cmd.op   = o;
        cmd.ch   = ch;
        cmd.bg   = bg;
        cmd.fg   = fg;
        cmd.line = line;
        cmd.col  = col;
        cmd_backlog.push_back(cmd);
    endfunction

    // Typing-like mix: text with plenty of spaces, newlines and backspaces,
    // reads aimed mostly at the visible area, the odd clear and no-op.
    function automatic console_cmd_t random_cmd();
        console_cmd_t cmd;
        int roll;
        int clear_pct;
        int rows;
        int cols;
        rows      = vis_rows();
        cols      = vis_cols();
        // clears are slow on a big screen, and needed often on a tiny one
        clear_pct = (rows * cols > 100) ? 2 : 6;
        cmd.op    = OP_PUT;
        cmd.ch    = CHAR_W'($urandom_range(0, 255));
        cmd.bg    = NIB_W'($urandom_range(0, 15));
        cmd.fg    = NIB_W'($urandom_range(0, 15));
        cmd.line  = LINE_W'($urandom_range(0, 31));
        cmd.col   = COL_W'($urandom_range(0, 127));
        roll      = $urandom_range(0, 99);
        if (roll < 16)
            cmd.ch = CH_SPACE;
        else if (roll < 26)
            cmd.ch = CH_NEWLINE;
        else if (roll < 40)
            cmd.ch = CH_BACKSPACE;
        else if (roll < 62)
            ;   // any byte
        else if (roll < 80)
        begin
            cmd.op = OP_READ;
            if ($urandom_range(0, 4) != 0)
            begin
                cmd.line = LINE_W'($urandom_range(0, rows - 1));
                cmd.col  = COL_W'($urandom_range(0, cols - 1));
            end
        end
        else if (roll < 80 + clear_pct)
            cmd.op = OP_CLEAR;
        else if (roll < 84 + clear_pct)
            cmd.op = OP_NONE;
        return cmd;
    endfunction

    // Both registers, one write each; the block is idle when this runs
    task automatic set_screen(input int rows_val, input int cols_val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_ROWS_IN_USE;
        cfg_data  <= CFG_DATA_W'(rows_val);
        rows_cfg   = rows_val & 'h1F;
        @(posedge clk);
        cfg_index <= REG_COLUMNS_IN_USE;
        cfg_data  <= CFG_DATA_W'(cols_val);
        cols_cfg   = cols_val & 'h7F;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Every request sent and every result back; sampled away from the edge
    task automatic wait_idle();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || push || status_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers requests from the backlog. A request stays on the ports
    // until push && !full; the prediction is made at that edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (!(push && full))
        begin
            if (push)
            begin
                status_due.push_back(next_status(in_flight));
                push_wait = pick_gap(push_steady);
                if ($urandom_range(0, 49) == 0)
                    push_steady = !push_steady;
                // now and then let the result side run dry before going on
                if ($urandom_range(0, 99) == 0)
                    draining = 1'b1;
            end
            if (draining && status_due.size() == 0)
                draining = 1'b0;
            if (push_wait > 0)
            begin
                push_wait--;
                push <= 1'b0;
            end
            else if (!draining && cmd_backlog.size() != 0)
            begin
                in_flight    = cmd_backlog.pop_front();
                op          <= in_flight.op;
                char_code   <= in_flight.ch;
                background  <= in_flight.bg;
                foreground  <= in_flight.fg;
                read_line   <= in_flight.line;
                read_column <= in_flight.col;
                push        <= 1'b1;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes results with random stalls and checks each one against
    // the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        console_status_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (status_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no request outstanding, expected none, %s",
                             $time, "actual one");
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("cursor_line", int'(want.row), int'(cursor_line));
                    check_field("cursor_column", int'(want.column), int'(cursor_column));
                    check_field("cell_char", int'(want.ch), int'(cell_char));
                    check_field("cell_attribute", int'(want.attr), int'(cell_attribute));
                    check_field("write_dropped", int'(want.dropped), int'(write_dropped));
                end
                pop_wait = pick_gap(pop_steady);
                if ($urandom_range(0, 49) == 0)
                    pop_steady = !pop_steady;
            end
            if (pop_wait > 0)
            begin
                pop_wait--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed cases on tiny screens, then random phases,
    // each under its own screen size.
    // ------------------------------------------------------------------------
    int phase_rows [6] = '{25, 31, 1, 0, 25, 1};
    int phase_cols [6] = '{80, 127, 1, 0, 1, 80};

    initial
    begin
        rst_n = 1'b0;
        foreach (screen_copy[i])
            screen_copy[i] = BLANK_CELL;
        rows_cfg = int'(ROWS_RESET);
        cols_cfg = int'(COLS_RESET);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // 2 lines x 3 columns: wrap, line scans, falling off the bottom
        set_screen(2, 3);
        add_cmd(OP_PUT,   8'h41,        4'hF, 4'h0, 5'd0,  7'd0);
        add_cmd(OP_PUT,   8'h00,        4'h0, 4'hF, 5'd0,  7'd0);
        add_cmd(OP_PUT,   8'hFF,        4'hA, 4'h5, 5'd0,  7'd0);  // wraps
        add_cmd(OP_READ,  8'h00,        4'h0, 4'h0, 5'd0,  7'd0);
        add_cmd(OP_READ,  8'h00,        4'h0, 4'h0, 5'd0,  7'd2);
        // back onto a full line: cursor saturates on its last cell
        add_cmd(OP_PUT,   CH_BACKSPACE, 4'h0, 4'h0, 5'd0,  7'd0);
        add_cmd(OP_PUT,   CH_BACKSPACE, 4'h0, 4'h0, 5'd0,  7'd0);
        add_cmd(OP_PUT,   CH_NEWLINE,   4'h0, 4'h0, 5'd0,  7'd0);
        add_cmd(OP_PUT,   CH_SPACE,     4'h3, 4'hC, 5'd0,  7'd0);
        add_cmd(OP_PUT,   CH_NEWLINE,   4'h0, 4'h0, 5'd0,  7'd0);  // below
        add_cmd(OP_PUT,   8'h42,        4'h1, 4'h2, 5'd0,  7'd0);  // dropped
        add_cmd(OP_PUT,   CH_NEWLINE,   4'h0, 4'h0, 5'd0,  7'd0);  // dropped
        // from below the screen onto a blank line: ends at column 0; then up onto line 0
        add_cmd(OP_PUT,   CH_BACKSPACE, 4'h0, 4'h0, 5'd0,  7'd0);
        add_cmd(OP_PUT,   CH_BACKSPACE, 4'h0, 4'h0, 5'd0,  7'd0);
        // reads outside the store and at its far corner
        add_cmd(OP_READ,  8'h00,        4'h0, 4'h0, 5'd31, 7'd127);
        add_cmd(OP_READ,  8'h00,        4'h0, 4'h0, 5'd24, 7'd79);
        add_cmd(OP_READ,  8'h00,        4'h0, 4'h0, 5'd0,  7'd80);
        add_cmd(OP_NONE,  8'hFF,        4'hF, 4'hF, 5'd31, 7'd127);
        add_cmd(OP_PUT,   8'h7E,        4'h9, 4'h6, 5'd0,  7'd0);
        add_cmd(OP_PUT,   8'h55,        4'h6, 4'h9, 5'd0,  7'd0);
        wait_idle();

        // shrink to 1x1 (registers at zero): cursor now below and past the edge
        set_screen(0, 0);
        add_cmd(OP_PUT,   CH_BACKSPACE, 4'h0, 4'h0, 5'd0,  7'd0);  // dropped
        add_cmd(OP_PUT,   CH_BACKSPACE, 4'h0, 4'h0, 5'd0,  7'd0);
        add_cmd(OP_PUT,   8'h43,        4'h2, 4'h4, 5'd0,  7'd0);
        add_cmd(OP_CLEAR, 8'h00,        4'h0, 4'h0, 5'd0,  7'd0);
        // outside the 1x1 area, so the clear left it alone
        add_cmd(OP_READ,  8'h00,        4'h0, 4'h0, 5'd0,  7'd1);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 6)
                set_screen(phase_rows[p], phase_cols[p]);
            else if (p == PHASES - 1)
                set_screen($urandom_range(0, 31), $urandom_range(0, 127));
            else
                set_screen($urandom_range(1, 6), $urandom_range(1, 12));
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                cmd_backlog.push_back(random_cmd());
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hang guard: far beyond a run where every request is a full-screen clear
    initial
    begin
        #120_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_cmd_queue.sv
src/tcw_back.sv
src/text_console_cell_writer_top.sv
tb/text_console_cell_writer_top_tb.sv
